// ===== rtl/assert_macros.svh =====
// Assertion macros used by the tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: lbl");
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition: lbl");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ===== rtl/dtst_pkg.sv =====
// Types and constants of the dirty tile set tracker.
package dtst_pkg;

   localparam int LIST_DEPTH = 32;
   localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

   typedef enum logic {
      CMD_MARK  = 1'b0,
      CMD_FLUSH = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      STAT_ADDED   = 3'd0,
      STAT_MARKED  = 3'd1,
      STAT_FULL    = 3'd2,
      STAT_FLUSHED = 3'd3,
      STAT_EMPTY   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_EMIT,
      S_FLUSH_RD,
      S_FLUSH_OUT
   } state_type;

   typedef struct packed {
      logic [7:0] owner;
      logic [7:0] col;
      logic [7:0] row;
   } entry_type;

endpackage

// ===== rtl/dirty_tile_set_tracker.sv =====
// Top level of the dirty tile set tracker: list memory, scan sequencer, result register.
//
// Keeps up to LIST_DEPTH dirty tiles, each with the entity that marked it first.
// Request channel (req_*): tuser is the command (mark or flush), tdata carries
// entity, column and row. Response channel (rsp_*): tuser is the status, tdata
// carries owner, column and row, tlast marks the final result of a request.
// A mark walks the stored entries through one comparator, one entry per cycle
// behind a registered memory read, and returns one result; an empty or full
// list gives its result without a scan. A mark holds the block until its
// result is loaded into the output register.
// A flush reads one entry and emits it before reading the next, then
// empties the list; an empty list gives a single empty result.
// One request is in work at a time; req_tready is high while the sequencer
// is idle, also while the last result still waits in the output register.
// A stalled receiver holds the output register and the sequencer waits
// before loading the next result; nothing is dropped.
// Reset empties the list at once; stored entries need no clearing.
module dirty_tile_set_tracker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // entity_index[7:0], tile_column[15:8], tile_row[23:16]
   input  logic [0:0]  req_tuser,   // cmd[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // owner_entity[7:0], out_column[15:8], out_row[23:16]
   output logic [2:0]  rsp_tuser,   // status[2:0]
   output logic        rsp_tlast    // last
);
   import dtst_pkg::*;
`include "assert_macros.svh"

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             rd_vld_ff, rd_vld_in;
   logic             rd_last_ff, rd_last_in;
   entry_type        rd_data_ff;
   entry_type        mem [LIST_DEPTH];

   logic [7:0]       ent_ff, ent_in;
   logic [7:0]       col_ff, col_in;
   logic [7:0]       row_ff, row_in;
   status_type       pend_status_ff, pend_status_in;
   logic [7:0]       pend_owner_ff, pend_owner_in;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   entry_type        rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             accept;
   logic             out_free;
   logic             match;
   logic             list_full;
   logic             list_empty;
   logic             rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic             wr_en;
   logic             load;
   logic             flush_last;
   logic [CNT_W-1:0] idx_next;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign list_full  = (count_ff == CNT_W'(LIST_DEPTH));
   assign list_empty = (count_ff == '0);
   assign idx_next   = idx_ff + CNT_W'(1);
   assign flush_last = (idx_next == count_ff);
   assign match      = rd_vld_ff && (rd_data_ff.col == col_ff) && (rd_data_ff.row == row_ff);

   // Next state of the sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (cmd_type'(req_tuser[0]) == CMD_FLUSH) begin
                  state_in = list_empty ? S_EMIT : S_FLUSH_RD;
               end else begin
                  state_in = (list_full || list_empty) ? S_EMIT : S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (rd_vld_ff && (match || rd_last_ff)) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_FLUSH_RD: begin
            state_in = S_FLUSH_OUT;
         end
         S_FLUSH_OUT: begin
            if (out_free) begin
               state_in = flush_last ? S_IDLE : S_FLUSH_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Datapath control of the sequencer
   always_comb begin
      count_in       = count_ff;
      idx_in         = idx_ff;
      rd_vld_in      = rd_vld_ff;
      rd_last_in     = rd_last_ff;
      ent_in         = ent_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      pend_status_in = pend_status_ff;
      pend_owner_in  = pend_owner_ff;
      rd_en          = 1'b0;
      rd_addr        = idx_ff[ADDR_W-1:0];
      wr_en          = 1'b0;
      load           = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_last_in    = rsp_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ent_in     = req_tdata[7:0];
               col_in     = req_tdata[15:8];
               row_in     = req_tdata[23:16];
               idx_in     = '0;
               rd_vld_in  = 1'b0;
               rd_last_in = 1'b0;
               pend_owner_in = 8'd0;
               if (cmd_type'(req_tuser[0]) == CMD_FLUSH) begin
                  pend_status_in = STAT_EMPTY;
               end else if (list_full) begin
                  pend_status_in = STAT_FULL;
               end else begin
                  pend_status_in = STAT_ADDED;
                  pend_owner_in  = req_tdata[7:0];
               end
            end
         end
         S_SCAN: begin
            // Issue one read per cycle, compare the entry read in the cycle before
            rd_en      = (idx_ff < count_ff);
            rd_vld_in  = rd_en;
            rd_last_in = flush_last;
            if (rd_en) begin
               idx_in = idx_next;
            end
            if (match) begin
               pend_status_in = STAT_MARKED;
               pend_owner_in  = rd_data_ff.owner;
               rd_vld_in      = 1'b0;
            end else if (rd_vld_ff && rd_last_ff) begin
               pend_status_in = STAT_ADDED;
               pend_owner_in  = ent_ff;
               rd_vld_in      = 1'b0;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               load          = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_data_in   = '{owner: pend_owner_ff, col: 8'd0, row: 8'd0};
               rsp_last_in   = 1'b1;
               // Append the new tile when its result goes out
               if (pend_status_ff == STAT_ADDED) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
         S_FLUSH_RD: begin
            rd_en = 1'b1;
         end
         S_FLUSH_OUT: begin
            if (out_free) begin
               load          = 1'b1;
               rsp_status_in = STAT_FLUSHED;
               rsp_data_in   = rd_data_ff;
               rsp_last_in   = flush_last;
               if (flush_last) begin
                  count_in = '0;
               end else begin
                  idx_in = idx_next;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Hold the result until taken, reload when free
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      rd_last_ff     <= rd_last_in;
      ent_ff         <= ent_in;
      col_ff         <= col_in;
      row_ff         <= row_in;
      pend_status_ff <= pend_status_in;
      pend_owner_ff  <= pend_owner_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // Entry list memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[ADDR_W-1:0]] <= '{owner: ent_ff, col: col_ff, row: row_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_data_ff.row, rsp_data_ff.col, rsp_data_ff.owner};
   assign rsp_tlast  = rsp_last_ff;

   `ASSERT_NEVER(a_count_bound, clock, reset, count_ff > CNT_W'(LIST_DEPTH))
   `ASSERT_PROP(a_add_grows, clock, reset, (load && rsp_status_in == STAT_ADDED) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
   `ASSERT_PROP(a_flush_clears, clock, reset, (load && rsp_status_in == STAT_FLUSHED && rsp_last_in) |=> (count_ff == '0))
   `ASSERT_PROP(a_full_only_full, clock, reset, (load && rsp_status_in == STAT_FULL) |-> list_full)
   `ASSERT_PROP(a_cmp_in_range, clock, reset, (state_ff == S_SCAN && rd_en && !match) |=> (rd_vld_ff && !list_full))

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the dirty tile set tracker: mirrored tile list, marks and flushes.
module testbench;
   import dtst_pkg::*;

   localparam int ITEM_TARGET  = 320;
   localparam int HOLD_AT      = 240;
   localparam int HOLD_CYCLES  = 400;
   localparam int QUIET_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 16;

   // One result as seen on the response channel
   typedef struct packed {
      status_type status;
      logic [7:0] owner;
      logic [7:0] col;
      logic [7:0] row;
      logic       last;
   } tile_report_type;

   // Mirror of the tile list plus the queue of reports it predicts
   class tile_list_scoreboard;
      entry_type       dirty_tiles [LIST_DEPTH];
      int unsigned     dirty_count = 0;
      tile_report_type reports_due [$];
      int unsigned     error_count = 0;

      task report(input string msg);
         error_count++;
         if (error_count <= 100) begin
            $display("%0t ns  mismatch: %s", $time, msg);
         end
      endtask

      function void push_report(input status_type st, input logic [7:0] own,
                                input logic [7:0] col, input logic [7:0] row,
                                input logic lst);
         tile_report_type r;
         r.status = st;
         r.owner  = own;
         r.col    = col;
         r.row    = row;
         r.last   = lst;
         reports_due.push_back(r);
      endfunction

      // Apply one accepted command to the mirrored list and queue its reports
      function void note_request(input cmd_type cmd, input logic [7:0] ent,
                                 input logic [7:0] col, input logic [7:0] row);
         int unsigned k;
         bit          found;
         if (cmd == CMD_FLUSH) begin
            if (dirty_count == 0) begin
               push_report(STAT_EMPTY, 8'd0, 8'd0, 8'd0, 1'b1);
            end else begin
               for (k = 0; k < dirty_count; k++) begin
                  push_report(STAT_FLUSHED, dirty_tiles[k].owner, dirty_tiles[k].col,
                              dirty_tiles[k].row, (k + 1 == dirty_count));
               end
            end
            dirty_count = 0;
         end else if (dirty_count >= LIST_DEPTH) begin
            // full list wins even over a tile that is already stored
            push_report(STAT_FULL, 8'd0, 8'd0, 8'd0, 1'b1);
         end else begin
            found = 1'b0;
            for (k = 0; k < dirty_count && !found; k++) begin
               if (dirty_tiles[k].col == col && dirty_tiles[k].row == row) begin
                  found = 1'b1;
                  push_report(STAT_MARKED, dirty_tiles[k].owner, 8'd0, 8'd0, 1'b1);
               end
            end
            if (!found) begin
               dirty_tiles[dirty_count] = {ent, col, row};
               dirty_count++;
               push_report(STAT_ADDED, ent, 8'd0, 8'd0, 1'b1);
            end
         end
      endfunction

      // Compare one accepted result against the oldest pending report
      task check_result(input logic [2:0] st, input logic [7:0] own,
                        input logic [7:0] col, input logic [7:0] row, input logic lst);
         tile_report_type want;
         if (reports_due.size() == 0) begin
            report($sformatf("unexpected result status %0d owner %0d", st, own));
            return;
         end
         want = reports_due.pop_front();
         if (st !== want.status)
            report($sformatf("status got %0d want %0d", st, want.status));
         if (own !== want.owner)
            report($sformatf("owner got %0d want %0d", own, want.owner));
         if (col !== want.col)
            report($sformatf("column got %0d want %0d", col, want.col));
         if (row !== want.row)
            report($sformatf("row got %0d want %0d", row, want.row));
         if (lst !== want.last)
            report($sformatf("last got %0b want %0b", lst, want.last));
      endtask

      function int unsigned pending();
         return reports_due.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;    // entity_index[7:0], tile_column[15:8], tile_row[23:16]
   logic [0:0]  req_tuser = '0;    // cmd[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // owner_entity[7:0], out_column[15:8], out_row[23:16]
   logic [2:0]  rsp_tuser;         // status[2:0]
   logic        rsp_tlast;

   tile_list_scoreboard sb;
   int  sent_count = 0;
   int  send_idle_pct = 21;
   int  recv_idle_pct = 54;
   bit  hold_rsp = 1'b0;

   dirty_tile_set_tracker uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offer one item, idling at random first, and return once it is accepted
   task send_item(input cmd_type cmd, input logic [7:0] ent,
                  input logic [7:0] col, input logic [7:0] row);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {row, col, ent};
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, ent, col, row);
      sent_count++;
   endtask

   task flush_list();
      send_item(CMD_FLUSH, 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)));
   endtask

   // Fill the list with distinct columns, hit it while full, then drain it
   task fill_then_flush();
      logic [7:0] base_col;
      logic [7:0] first_row;
      int         k;
      base_col  = 8'($urandom_range(255));
      first_row = 8'($urandom_range(255));
      send_item(CMD_MARK, 8'($urandom_range(255)), base_col, first_row);
      for (k = 1; k < LIST_DEPTH; k++) begin
         send_item(CMD_MARK, 8'($urandom_range(255)), base_col + 8'(k),
                   8'($urandom_range(255)));
      end
      send_item(CMD_MARK, 8'($urandom_range(255)), base_col, first_row);
      send_item(CMD_MARK, 8'($urandom_range(255)), base_col - 8'd1,
                8'($urandom_range(255)));
      flush_list();
   endtask

   // Run of marks on a narrow or wide tile range, usually closed by a flush
   task random_burst();
      int         len;
      int         k;
      bit         narrow;
      logic [7:0] col;
      logic [7:0] row;
      len    = ($urandom_range(99) < 25) ? $urandom_range(40, 28) : $urandom_range(12, 1);
      narrow = 1'($urandom_range(1));
      for (k = 0; k < len; k++) begin
         if (narrow) begin
            col = $urandom_range(1) ? 8'($urandom_range(3)) : 8'(255 - $urandom_range(3));
            row = $urandom_range(1) ? 8'($urandom_range(3)) : 8'(255 - $urandom_range(3));
         end else begin
            col = 8'($urandom_range(255));
            row = 8'($urandom_range(255));
         end
         send_item(CMD_MARK, 8'($urandom_range(255)), col, row);
      end
      if ($urandom_range(99) < 80) begin
         flush_list();
         if ($urandom_range(99) < 10) begin
            flush_list();
         end
      end
   endtask

   // Drive the receiver ready, forced low during the long hold-off
   always @(negedge clock) begin
      rsp_tready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
   end

   // Hold off the receiver once while the sender keeps offering items
   initial begin : long_hold
      wait (sent_count >= HOLD_AT);
      hold_rsp = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp = 1'b0;
   end

   // Check every accepted result
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tuser, rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16],
                         rsp_tlast);
      end
   end

   // End the run when nothing moves on either channel for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      int phase;
      int last_phase;
      sb = new;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Directed: empty flush, extreme tiles, repeats of stored tiles, flushes
      flush_list();
      send_item(CMD_MARK, 8'h00, 8'h00, 8'h00);
      send_item(CMD_MARK, 8'hFF, 8'hFF, 8'hFF);
      send_item(CMD_MARK, 8'hAA, 8'hFF, 8'h00);
      send_item(CMD_MARK, 8'h55, 8'h00, 8'hFF);
      send_item(CMD_MARK, 8'h12, 8'h00, 8'h00);
      send_item(CMD_MARK, 8'h34, 8'hFF, 8'hFF);
      send_item(CMD_MARK, 8'hC3, 8'h00, 8'hFF);
      send_item(CMD_MARK, 8'h3C, 8'h01, 8'h00);
      flush_list();
      flush_list();
      send_item(CMD_MARK, 8'h80, 8'h80, 8'h7F);
      send_item(CMD_MARK, 8'h01, 8'h80, 8'h7F);
      flush_list();

      // Random: three idling phases, each opened by a full-list pass
      last_phase = -1;
      while (sent_count < ITEM_TARGET) begin
         if (sent_count < ITEM_TARGET / 3)
            phase = 0;
         else if (sent_count < 2 * ITEM_TARGET / 3)
            phase = 1;
         else
            phase = 2;
         case (phase)
            0: begin
               send_idle_pct = 21;
               recv_idle_pct = 54;
            end
            1: begin
               send_idle_pct = 54;
               recv_idle_pct = 21;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         if (phase != last_phase) begin
            last_phase = phase;
            fill_then_flush();
         end
         random_burst();
      end

      @(negedge clock);
      req_tvalid <= 1'b0;

      // Drain, then allow the last results to settle
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.report($sformatf("%0d results never arrived", sb.pending()));
      end
      if (sb.error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
